### hw/rtl/nps_pkg.sv
`default_nettype none
// ============================================================================
// nps_pkg - shared definitions for the next-prime search block
// Widths, constants, sequencer states and the request/status structs that
// pass between the sequencer and the remainder unit.
// ============================================================================
package nps_pkg;

    localparam int VALUE_WIDTH = 32;                 // signed input width
    localparam int CAND_W      = VALUE_WIDTH - 1;    // positive range, result width
    localparam int CNT_W       = $clog2(CAND_W + 1);
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CAND_W + 7) / 8) * 8;

    localparam logic [CAND_W-1:0]  ANSWER_ONE   = CAND_W'(1);
    localparam logic [CAND_W-1:0]  ANSWER_TWO   = CAND_W'(2);
    localparam logic [CAND_W-1:0]  ANSWER_THREE = CAND_W'(3);
    localparam logic [CAND_W-1:0]  FACTOR_FIRST = CAND_W'(3);
    localparam logic [VALUE_WIDTH:0] SQUARE_FIRST = (VALUE_WIDTH + 1)'(9);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [CAND_W-1:0] dividend;
        logic [CAND_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_stat_t;

endpackage
`default_nettype wire

### hw/rtl/nps_rem_unit.sv
`default_nettype none
// ============================================================================
// nps_rem_unit - bit-serial remainder unit
// Restoring shift-subtract division, one dividend bit per cycle. Reports
// when the remainder is done and whether it is zero.
// ============================================================================
module nps_rem_unit
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nps_pkg::rem_req_t  req,
    output nps_pkg::rem_stat_t      stat
);
    import nps_pkg::*;

    logic [CAND_W-1:0] rem_reg,  rem_next;
    logic [CAND_W-1:0] dvd_reg,  dvd_next;
    logic [CAND_W-1:0] divr_reg, divr_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [CAND_W:0]   trial;
    logic [CAND_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[CAND_W-1]};
        diff  = trial - {1'b0, divr_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        divr_next = divr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            divr_next = req.divisor;
            cnt_next  = CNT_W'(CAND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restore when the divisor does not fit
            if (trial >= {1'b0, divr_reg})
            begin
                rem_next = diff[CAND_W-1:0];
            end
            else
            begin
                rem_next = trial[CAND_W-1:0];
            end
            dvd_next = {dvd_reg[CAND_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        divr_reg <= divr_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule
`default_nettype wire

### hw/rtl/next_prime_search.sv
`default_nettype none
// ============================================================================
// next_prime_search - first prime above a signed integer (1 for starts <= 0)
// Trial division of odd candidates by odd factors up to the square root,
// sequenced over a shared bit-serial remainder unit.
// ============================================================================
//  channel   | dir | tdata                    | tuser
//  s_*       | in  | start_value (signed)     | -
//  m_*       | out | next_prime, zero padded  | overflow
//
//  Each trial factor takes one pass of the remainder unit, which handles
//  one dividend bit per cycle; a request takes the sum of these passes over
//  every factor tried on every candidate. Trivial starts skip trial division.
//  s_tready is high only while the sequencer is idle; a finished result
//  waits in the output register, and the next request may be taken then.
//  Reset is asynchronous and clears control state only.
// ============================================================================
module next_prime_search
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [nps_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] start_value
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [nps_pkg::OUT_TDATA_W-1:0] m_tdata,   // [30:0] next_prime
    output logic                                 m_tuser    // [0] overflow
);
    import nps_pkg::*;

    state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] cand_reg, cand_next;
    logic [CAND_W-1:0]      f_reg,    f_next;
    logic [VALUE_WIDTH:0]   sq_reg,   sq_next;
    logic [CAND_W-1:0]      res_reg,  res_next;
    logic                   rovf_reg, rovf_next;

    logic                   out_valid_reg;
    logic [CAND_W-1:0]      out_prime_reg;
    logic                   out_ovf_reg;

    rem_req_t               rem_req;
    rem_stat_t              rem_stat;

    logic [VALUE_WIDTH-1:0] start_v;
    logic                   accept;
    logic                   trivial;
    logic                   cand_ovf;
    logic                   bound_hit;
    logic                   load_out;

    nps_rem_unit u_rem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .stat  (rem_stat)
    );

    assign start_v   = s_tdata[VALUE_WIDTH-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign trivial   = start_v[VALUE_WIDTH-1] || (start_v <= VALUE_WIDTH'(2));
    assign cand_ovf  = cand_reg[VALUE_WIDTH-1];
    assign bound_hit = (sq_reg > {1'b0, cand_reg});
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = trivial ? ST_FINISH : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (cand_ovf || bound_hit) ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and unit requests
    always_comb
    begin
        cand_next        = cand_reg;
        f_next           = f_reg;
        sq_next          = sq_reg;
        res_next         = res_reg;
        rovf_next        = rovf_reg;
        rem_req.start    = 1'b0;
        rem_req.dividend = cand_reg[CAND_W-1:0];
        rem_req.divisor  = f_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rovf_next = 1'b0;
                    f_next    = FACTOR_FIRST;
                    sq_next   = SQUARE_FIRST;
                    cand_next = (start_v + VALUE_WIDTH'(1)) | VALUE_WIDTH'(1);
                    priority if (start_v[VALUE_WIDTH-1] || start_v == '0)
                    begin
                        res_next = ANSWER_ONE;
                    end
                    else if (start_v == VALUE_WIDTH'(1))
                    begin
                        res_next = ANSWER_TWO;
                    end
                    else
                    begin
                        res_next = ANSWER_THREE;
                    end
                end
            end
            ST_CHECK:
            begin
                priority if (cand_ovf)
                begin
                    res_next  = '0;
                    rovf_next = 1'b1;
                end
                else if (bound_hit)
                begin
                    res_next = cand_reg[CAND_W-1:0];
                end
                else
                begin
                    rem_req.start = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        // composite: advance to next odd candidate
                        cand_next = cand_reg + VALUE_WIDTH'(2);
                        f_next    = FACTOR_FIRST;
                        sq_next   = SQUARE_FIRST;
                    end
                    else
                    begin
                        // (f+2)^2 = f^2 + 4f + 4
                        f_next  = f_reg + CAND_W'(2);
                        sq_next = sq_reg + {f_reg, 2'b00} + (VALUE_WIDTH + 1)'(4);
                    end
                end
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        f_reg    <= f_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
        rovf_reg <= rovf_next;
        if (load_out)
        begin
            out_prime_reg <= res_reg;
            out_ovf_reg   <= rovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_prime_reg);
    assign m_tuser  = out_ovf_reg;

endmodule
`default_nettype wire

### hw/rtl/nps_checker.sv
`default_nettype none
// ============================================================================
// nps_checker - port-level checks for the next-prime search block
// Watches the stream ports over time; attached to the top level by bind.
// ============================================================================
module nps_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [nps_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [nps_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                            m_tuser
);
    import nps_pkg::*;

    // overflow reports a zero prime
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[CAND_W-1:0] == '0))
        else $error("overflow with nonzero result");

    // a normal result is never zero
    a_prime_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[CAND_W-1:0] != '0))
        else $error("zero result without overflow");

    // sequencer is not ready in the cycle after it accepts a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after accepted request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind next_prime_search nps_checker u_nps_checker (.*);
`default_nettype wire
